// ===== rtl/core/mpct_pkg.sv =====
// mpct_pkg: shared types and constants for the mouse packet cursor tracker
// no dependencies; imported by every module of the block

package mpct_pkg;

    localparam int ColW  = 7;
    localparam int RowW  = 6;
    localparam int CellW = 13;

    localparam logic [1:0] EV_MOVE = 2'd0;
    localparam logic [1:0] EV_DOWN = 2'd1;
    localparam logic [1:0] EV_UP   = 2'd2;

    localparam logic [1:0] REG_ENABLE  = 2'd0;
    localparam logic [1:0] REG_COLUMNS = 2'd1;
    localparam logic [1:0] REG_ROWS    = 2'd2;

    localparam logic            RST_ENABLE  = 1'b1;
    localparam logic [ColW-1:0] RST_COLUMNS = 7'd80;
    localparam logic [RowW-1:0] RST_ROWS    = 6'd25;
    localparam logic [ColW-1:0] RST_POS_X   = 7'd40;
    localparam logic [RowW-1:0] RST_POS_Y   = 6'd12;

    localparam int MouseBit = 5;

    typedef struct packed {
        logic [7:0] ctrl_status;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]       event_kind;
        logic [1:0]       button_number;
        logic [ColW-1:0]  cursor_x;
        logic [RowW-1:0]  cursor_y;
        logic [CellW-1:0] old_cell;
        logic [CellW-1:0] new_cell;
        logic             last;
    } t_out;

    typedef struct packed {
        logic            enabled;
        logic [ColW-1:0] columns;
        logic [RowW-1:0] rows;
    } t_cfg;

    typedef struct packed {
        logic [ColW-1:0]  pos_x;
        logic [RowW-1:0]  pos_y;
        logic [CellW-1:0] old_cell;
        logic [2:0]       changed;
        logic [2:0]       prev_buttons;
    } t_bundle;

endpackage

// ===== rtl/core/mpct_regs.sv =====
// mpct_regs: apb-style configuration registers (enable, columns, rows)
// depends on mpct_pkg; columns and rows of zero are presented as one

module mpct_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output mpct_pkg::t_cfg o_cfg
);
    import mpct_pkg::*;

    logic            r_enable;
    logic [ColW-1:0] r_columns;
    logic [RowW-1:0] r_rows;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= RST_ENABLE;
            r_columns <= RST_COLUMNS;
            r_rows    <= RST_ROWS;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_ENABLE:  r_enable  <= pwdata[0];
                REG_COLUMNS: r_columns <= pwdata[ColW-1:0];
                REG_ROWS:    r_rows    <= pwdata[RowW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ENABLE:  prdata = {31'd0, r_enable};
            REG_COLUMNS: prdata = {{(32-ColW){1'b0}}, r_columns};
            REG_ROWS:    prdata = {{(32-RowW){1'b0}}, r_rows};
            default:     prdata = 32'd0;
        endcase
    end

    assign o_cfg.enabled = r_enable;
    assign o_cfg.columns = (r_columns == '0) ? ColW'(1) : r_columns;
    assign o_cfg.rows    = (r_rows == '0) ? RowW'(1) : r_rows;

endmodule

// ===== rtl/core/mpct_decode.sv =====
// mpct_decode: input register, packet gathering, cursor update and clamp
// depends on mpct_pkg; hands one bundle per finished packet to mpct_emit

module mpct_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpct_pkg::t_cfg    i_cfg,
    input  logic              i_in_valid,
    input  mpct_pkg::t_in     i_in_data,
    output logic              o_in_stall,
    input  logic              i_bun_take,
    output logic              o_bun_load,
    output mpct_pkg::t_bundle o_bun
);
    import mpct_pkg::*;

    logic             r_in_valid;
    t_in              r_in;
    logic [1:0]       r_byte_idx;
    logic [7:0]       r_pkt0;
    logic [7:0]       r_pkt1;
    logic [ColW-1:0]  r_pos_x;
    logic [RowW-1:0]  r_pos_y;
    logic [2:0]       r_prev;

    logic             taken;
    logic             completes;
    logic             adv;
    logic signed [8:0] sx;
    logic signed [8:0] sy;
    logic [7:0]       dy8;
    logic [ColW-1:0]  n_pos_x;
    logic [RowW-1:0]  n_pos_y;
    logic [CellW-1:0] old_cell;

    assign taken      = r_in.ctrl_status[MouseBit] && i_cfg.enabled;
    assign completes  = taken && (r_byte_idx == 2'd2);
    assign adv        = r_in_valid && (!completes || i_bun_take);
    assign o_in_stall = r_in_valid && !adv;
    assign o_bun_load = r_in_valid && completes && i_bun_take;

    // negation in eight bits leaves -128 as -128
    assign dy8 = 8'(8'd0 - r_in.data_byte);
    assign sx  = $signed({2'b00, r_pos_x}) + $signed({r_pkt1[7], r_pkt1});
    assign sy  = $signed({3'b000, r_pos_y}) + $signed({dy8[7], dy8});

    always_comb begin
        if (sx[8]) begin
            n_pos_x = '0;
        end else if (sx[7:0] >= {1'b0, i_cfg.columns}) begin
            n_pos_x = ColW'(i_cfg.columns - ColW'(1));
        end else begin
            n_pos_x = sx[ColW-1:0];
        end
        if (sy[8]) begin
            n_pos_y = '0;
        end else if (sy[7:0] >= {2'b00, i_cfg.rows}) begin
            n_pos_y = RowW'(i_cfg.rows - RowW'(1));
        end else begin
            n_pos_y = sy[RowW-1:0];
        end
    end

    assign old_cell = CellW'(CellW'(r_pos_y) * CellW'(i_cfg.columns)) + CellW'(r_pos_x);

    assign o_bun.pos_x        = n_pos_x;
    assign o_bun.pos_y        = n_pos_y;
    assign o_bun.old_cell     = old_cell;
    assign o_bun.changed      = r_pkt0[2:0] ^ r_prev;
    assign o_bun.prev_buttons = r_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_byte_idx <= 2'd0;
            r_pos_x    <= RST_POS_X;
            r_pos_y    <= RST_POS_Y;
            r_prev     <= 3'd0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv && taken) begin
                if (completes) begin
                    r_byte_idx <= 2'd0;
                    r_pos_x    <= n_pos_x;
                    r_pos_y    <= n_pos_y;
                    r_prev     <= r_pkt0[2:0];
                end else begin
                    r_byte_idx <= 2'(r_byte_idx + 2'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (adv && taken && !completes) begin
            if (r_byte_idx[0]) begin
                r_pkt1 <= r_in.data_byte;
            end else begin
                r_pkt0 <= r_in.data_byte;
            end
        end
    end

endmodule

// ===== rtl/core/mpct_emit.sv =====
// mpct_emit: holds one packet bundle and sends its move and button beats
// depends on mpct_pkg; output register toward the result channel

module mpct_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpct_pkg::t_cfg    i_cfg,
    input  logic              i_bun_load,
    input  mpct_pkg::t_bundle i_bun,
    output logic              o_bun_take,
    output logic              o_out_valid,
    output mpct_pkg::t_out    o_out_data,
    input  logic              i_out_stall
);
    import mpct_pkg::*;

    logic             r_bun_valid;
    logic             r_move_pend;
    logic [2:0]       r_mask;
    t_bundle          r_bun;
    logic             r_out_valid;
    t_out             r_out;

    logic             out_ld;
    logic             done;
    logic [2:0]       pick;
    logic [2:0]       n_mask;
    logic [CellW-1:0] new_cell;
    t_out             n_out;

    assign out_ld     = !r_out_valid || !i_out_stall;
    assign new_cell   = CellW'(CellW'(r_bun.pos_y) * CellW'(i_cfg.columns)) + CellW'(r_bun.pos_x);
    assign pick       = r_mask & (~r_mask + 3'd1);

    always_comb begin
        n_out.cursor_x = r_bun.pos_x;
        n_out.cursor_y = r_bun.pos_y;
        n_out.new_cell = new_cell;
        if (r_move_pend) begin
            n_mask               = r_mask;
            n_out.event_kind     = EV_MOVE;
            n_out.button_number  = 2'd0;
            n_out.old_cell       = r_bun.old_cell;
            n_out.last           = (r_mask == 3'd0);
        end else begin
            n_mask               = r_mask & ~pick;
            n_out.event_kind     = ((r_bun.prev_buttons & pick) != 3'd0) ? EV_UP : EV_DOWN;
            n_out.button_number  = pick[0] ? 2'd1 : (pick[1] ? 2'd2 : 2'd3);
            n_out.old_cell       = new_cell;
            n_out.last           = (n_mask == 3'd0);
        end
    end

    assign done       = r_bun_valid && out_ld && n_out.last;
    assign o_bun_take = !r_bun_valid || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bun_valid <= 1'b0;
            r_move_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_bun_load) begin
                r_bun_valid <= 1'b1;
                r_move_pend <= 1'b1;
            end else if (r_bun_valid && out_ld) begin
                r_move_pend <= 1'b0;
                if (done) begin
                    r_bun_valid <= 1'b0;
                end
            end
            if (out_ld) begin
                r_out_valid <= r_bun_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bun_load) begin
            r_bun  <= i_bun;
            r_mask <= i_bun.changed;
        end else if (r_bun_valid && out_ld) begin
            r_mask <= n_mask;
        end
        if (out_ld && r_bun_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/mouse_packet_cursor_tracker_unit.sv =====
// mouse_packet_cursor_tracker_unit: top level of the mouse packet cursor tracker
// depends on mpct_pkg, mpct_regs, mpct_decode, mpct_emit
//
//   channel   handshake                    payload
//   input     i_in_valid / o_in_stall      i_in_data  (t_in: status, data byte)
//   result    o_out_valid / i_out_stall    o_out_data (t_out: kind, button, cursor, cells)
//   config    psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// a byte is decoded in the cycle after it is taken; the move beat of a packet goes from
// the bundle register to the output register; button beats follow one per cycle unless stalled
// a packet holds the result side for 1 to 4 beats: a move beat plus one per changed button
// the next third byte waits in the input register until the last of those beats moves
// into the output register; first and second bytes keep moving at one per cycle
// reset is synchronous; no clearing pass is needed after reset

module mouse_packet_cursor_tracker_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  mpct_pkg::t_in   i_in_data,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output mpct_pkg::t_out  o_out_data,
    input  logic            i_out_stall,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import mpct_pkg::*;

    t_cfg    cfg;
    t_bundle bun;
    logic    bun_load;
    logic    bun_take;

    mpct_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mpct_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_bun_take (bun_take),
        .o_bun_load (bun_load),
        .o_bun      (bun)
    );

    mpct_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_bun_load  (bun_load),
        .i_bun       (bun),
        .o_bun_take  (bun_take),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    a_move_no_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.event_kind == EV_MOVE) == (o_out_data.button_number == 2'd0)))
        else $error("move beat and button number disagree");

    a_button_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_kind != EV_MOVE)
            |-> (o_out_data.old_cell == o_out_data.new_cell))
        else $error("button beat with differing cells");

    a_bundle_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bun_load |-> bun_take)
        else $error("bundle loaded while previous one still in flight");

    a_move_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.last |=>
            o_out_valid && (o_out_data.event_kind != EV_MOVE))
        else $error("packet beats not contiguous");

endmodule
